// File: design/omni_wheel_speed_mixer_defines.svh
// Assertion macros for the omni wheel speed mixer
`ifndef OMNI_WHEEL_SPEED_MIXER_DEFINES_SVH
`define OMNI_WHEEL_SPEED_MIXER_DEFINES_SVH

// property that holds on every clock edge outside reset
`define OWM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/owm_pkg.sv
`timescale 1ns / 1ps
package owm_pkg;
	localparam int NumWheels = 4;
	localparam int CordicSteps = 13;
	localparam int CordicStart = 9949;
	localparam int FullTurn = 23040;
	localparam int HalfTurn = 180 * 64;
	localparam int QuarterTurn = HalfTurn / 2;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ANGLE_ONE   = 3'd0,
		REG_ANGLE_TWO   = 3'd1,
		REG_ANGLE_THREE = 3'd2,
		REG_ANGLE_FOUR  = 3'd3,
		REG_DRIVE_GAIN  = 3'd4,
		REG_TURN_ARM    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] speed_a;
		logic signed [15:0] heading_a;
		logic signed [15:0] speed_b;
		logic signed [15:0] heading_b;
		logic signed [15:0] turn_rate;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] drive_one;
		logic signed [15:0] drive_two;
		logic signed [15:0] drive_three;
		logic signed [15:0] drive_four;
	} out_word_t;

	// atan(2^-i) in 1/64 degree
	function automatic logic [11:0] step_angle(input int i);
		logic [11:0] t;
		case (i)
			0: t = 12'd2880;
			1: t = 12'd1700;
			2: t = 12'd898;
			3: t = 12'd456;
			4: t = 12'd229;
			5: t = 12'd115;
			6: t = 12'd57;
			7: t = 12'd29;
			8: t = 12'd14;
			9: t = 12'd7;
			10: t = 12'd4;
			11: t = 12'd2;
			12: t = 12'd1;
			default: t = 12'd0;
		endcase
		return t;
	endfunction
endpackage

// File: design/omni_wheel_speed_mixer.sv
`timescale 1ns / 1ps
// Pipeline stages from input accept to output valid: range reduce 2,
// CORDIC 14, multiply-accumulate 3; the pipe advances only when not stalled.
// Throughput: one word per cycle; a single global enable pipeline, the
// output register stalls the whole pipe while downstream stalls.
// Reset: arst_n clears valid bits and loads register defaults
// (angles 45/135/225/315, gain 256, arm 256).
module omni_wheel_speed_mixer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  owm_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output owm_pkg::out_word_t                  out_data,
	input  logic                                cfg_we,
	input  logic [owm_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [owm_pkg::CfgDataW-1:0]        cfg_wdata
);
	import owm_pkg::*;
	`include "omni_wheel_speed_mixer_defines.svh"

	localparam int Lat = CordicSteps + 1 + 5;

	logic [8:0] angle_q [NumWheels];
	logic signed [15:0] gain_q;
	logic [15:0] arm_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q[0] <= 9'd45;
			angle_q[1] <= 9'd135;
			angle_q[2] <= 9'd225;
			angle_q[3] <= 9'd315;
			gain_q <= 16'sd256;
			arm_q <= 16'd256;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ANGLE_ONE:   angle_q[0] <= cfg_wdata[8:0];
				REG_ANGLE_TWO:   angle_q[1] <= cfg_wdata[8:0];
				REG_ANGLE_THREE: angle_q[2] <= cfg_wdata[8:0];
				REG_ANGLE_FOUR:  angle_q[3] <= cfg_wdata[8:0];
				REG_DRIVE_GAIN:  gain_q <= cfg_wdata;
				REG_TURN_ARM:    arm_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// global advance: output register empty or being taken
	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	logic [Lat-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Lat-2:0], in_valid};
	end
	assign out_valid = vld_q[Lat-1];

	// stage 1: difference heading minus wheel angle, range [-65472, 32767]
	logic signed [17:0] d_s1 [2][NumWheels];
	logic signed [15:0] sa_s1, sb_s1, tr_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			sa_s1 <= in_data.speed_a;
			sb_s1 <= in_data.speed_b;
			tr_s1 <= in_data.turn_rate;
			for (int w = 0; w < NumWheels; w++) begin
				d_s1[0][w] <= 18'(in_data.heading_a) - 18'($signed({1'b0, angle_q[w], 6'b0}));
				d_s1[1][w] <= 18'(in_data.heading_b) - 18'($signed({1'b0, angle_q[w], 6'b0}));
			end
		end
	end

	// stage 2: reduce mod 360 deg to [-180,180), fold to +-90 deg
	logic signed [14:0] z_s2 [2][NumWheels];
	logic n_s2 [2][NumWheels];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				for (int w = 0; w < NumWheels; w++) begin
					logic signed [17:0] r;
					r = d_s1[v][w];
					// up to three full turns below zero
					if (r < 0) r = r + 18'(FullTurn);
					if (r < 0) r = r + 18'(FullTurn);
					if (r < 0) r = r + 18'(FullTurn);
					if (r >= 18'(FullTurn)) r = r - 18'(FullTurn);
					if (r >= 18'(HalfTurn)) r = r - 18'(FullTurn);
					if (r > 18'(QuarterTurn)) begin
						r = r - 18'(HalfTurn);
						n_s2[v][w] <= 1'b1;
					end else if (r < -18'(QuarterTurn)) begin
						r = r + 18'(HalfTurn);
						n_s2[v][w] <= 1'b1;
					end else begin
						n_s2[v][w] <= 1'b0;
					end
					z_s2[v][w] <= r[14:0];
				end
			end
		end
	end

	// speeds ride alongside the CORDIC pipes
	localparam int CLat = CordicSteps + 1;
	logic signed [15:0] sa_d [CLat+1];
	logic signed [15:0] sb_d [CLat+1];
	logic signed [15:0] tr_d [CLat+1];
	always_ff @(posedge clk) begin
		if (en) begin
			sa_d[0] <= sa_s1;
			sb_d[0] <= sb_s1;
			tr_d[0] <= tr_s1;
			for (int k = 1; k <= CLat; k++) begin
				sa_d[k] <= sa_d[k-1];
				sb_d[k] <= sb_d[k-1];
				tr_d[k] <= tr_d[k-1];
			end
		end
	end

	logic signed [15:0] cos_w [2][NumWheels];
	for (genvar v = 0; v < 2; v++) begin : g_vec
		for (genvar w = 0; w < NumWheels; w++) begin : g_wh
			owm_cordic u_cordic (
				.clk(clk), .en(en), .angle(z_s2[v][w]), .neg(n_s2[v][w]),
				.cos_val(cos_w[v][w])
			);
		end
	end

	// stage M1: projections and turn term (Q14)
	logic signed [31:0] pa_m1 [NumWheels];
	logic signed [31:0] pb_m1 [NumWheels];
	logic signed [38:0] tt_m1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int w = 0; w < NumWheels; w++) begin
				pa_m1[w] <= sa_d[CLat] * cos_w[0][w];
				pb_m1[w] <= sb_d[CLat] * cos_w[1][w];
			end
			tt_m1 <= (39'(tr_d[CLat]) * 39'($signed({1'b0, arm_q}))) <<< 6;
		end
	end

	// stage M2: sum
	logic signed [39:0] sum_m2 [NumWheels];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int w = 0; w < NumWheels; w++)
				sum_m2[w] <= 40'(pa_m1[w]) + 40'(pb_m1[w]) + 40'(tt_m1);
		end
	end

	// stage M3: negated gain, truncate toward zero, saturate (40x17 bits)
	out_word_t res;
	logic signed [15:0] drv_q [NumWheels];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int w = 0; w < NumWheels; w++) begin
				logic signed [56:0] p;
				logic signed [34:0] t;
				p = 57'(sum_m2[w]) * 57'(-17'(gain_q));
				if (p < 0) p = p + 57'((1 << 22) - 1);
				t = p[56:22];
				if (t > 35'sd32767) drv_q[w] <= 16'sh7fff;
				else if (t < -35'sd32768) drv_q[w] <= 16'sh8000;
				else drv_q[w] <= t[15:0];
			end
		end
	end

	assign res.drive_one = drv_q[0];
	assign res.drive_two = drv_q[1];
	assign res.drive_three = drv_q[2];
	assign res.drive_four = drv_q[3];
	assign out_data = res;

	`OWM_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_data),
		"output word changed under stall")
	`OWM_ASSERT(a_stall_en, in_stall == (out_valid && out_stall),
		"input stall not tied to output back-pressure")
	`OWM_ASSERT_NEXT(a_pipe_adv, en, vld_q[0] == $past(in_valid),
		"input valid not captured on advance")
endmodule

// File: design/owm_cordic.sv
`timescale 1ns / 1ps
// Pipelined cosine: angle in 1/64 degree (reduced to +-90 deg) in, Q1.14 out.
// Input stage followed by the rotation stages; advances only when en is high.
module owm_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic signed [14:0] angle,
	input  logic               neg,
	output logic signed [15:0] cos_val
);
	import owm_pkg::*;

	logic signed [15:0] x_q [CordicSteps+1];
	logic signed [15:0] y_q [CordicSteps+1];
	logic signed [14:0] z_q [CordicSteps+1];
	logic               n_q [CordicSteps+1];

	// input stage
	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= 16'(CordicStart);
			y_q[0] <= '0;
			z_q[0] <= angle;
			n_q[0] <= neg;
		end
	end

	// one rotation per stage
	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][14]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - $signed({3'b0, step_angle(i)});
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + $signed({3'b0, step_angle(i)});
				end
				n_q[i+1] <= n_q[i];
			end
		end
	end

	assign cos_val = n_q[CordicSteps] ? -x_q[CordicSteps] : x_q[CordicSteps];
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import owm_pkg::*;

	localparam int Latency = 19;
	localparam int IdleLimit = 20000;
	localparam int RandomWords = 1450;

	// fixed-point mixer prediction and pending expected drive words
	class drive_scoreboard;
		int unsigned angle[NumWheels];
		logic signed [15:0] gain;
		logic [15:0] arm;
		out_word_t pending[$];
		int errors;

		function new();
			angle[0] = 45;
			angle[1] = 135;
			angle[2] = 225;
			angle[3] = 315;
			gain = 16'sd256;
			arm = 16'd256;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] value);
			case (idx)
				REG_ANGLE_ONE: angle[0] = value[8:0];
				REG_ANGLE_TWO: angle[1] = value[8:0];
				REG_ANGLE_THREE: angle[2] = value[8:0];
				REG_ANGLE_FOUR: angle[3] = value[8:0];
				REG_DRIVE_GAIN: gain = value;
				REG_TURN_ARM: arm = value;
				default: ;
			endcase
		endfunction

		// arithmetic shift of a signed int rounds toward minus infinity
		function int cosine(int d);
			int x, y, z, nx;
			bit flip;
			int t[13];
			t = '{2880, 1700, 898, 456, 229, 115, 57, 29, 14, 7, 4, 2, 1};
			x = 9949;
			y = 0;
			flip = 0;
			d = d % 23040;
			if (d < 0) d += 23040;
			if (d >= 11520) d -= 23040;
			if (d > 5760) begin
				d -= 11520;
				flip = 1;
			end else if (d < -5760) begin
				d += 11520;
				flip = 1;
			end
			z = d;
			for (int i = 0; i < 13; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= t[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += t[i];
				end
				x = nx;
			end
			return flip ? -x : x;
		endfunction

		function logic signed [15:0] wheel_speed(int unsigned ang, in_word_t w);
			longint base, sum, v;
			base = longint'(ang) * 64;
			sum = longint'(w.speed_a) * cosine(int'(w.heading_a) - int'(base))
				+ longint'(w.speed_b) * cosine(int'(w.heading_b) - int'(base))
				+ longint'(w.turn_rate) * longint'({48'd0, arm}) * 64;
			v = (-longint'(gain) * sum) / (longint'(1) << 22);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[15:0];
		endfunction

		function void note_input(in_word_t w);
			out_word_t e;
			e.drive_one = wheel_speed(angle[0], w);
			e.drive_two = wheel_speed(angle[1], w);
			e.drive_three = wheel_speed(angle[2], w);
			e.drive_four = wheel_speed(angle[3], w);
			pending.push_back(e);
		endfunction

		function void check_output(out_word_t got);
			out_word_t e;
			if (pending.size() == 0) begin
				report_error($sformatf("unexpected drive word %h", got));
				return;
			end
			e = pending.pop_front();
			if (got.drive_one !== e.drive_one)
				report_error($sformatf("drive_one %0d exp %0d", got.drive_one, e.drive_one));
			if (got.drive_two !== e.drive_two)
				report_error($sformatf("drive_two %0d exp %0d", got.drive_two, e.drive_two));
			if (got.drive_three !== e.drive_three)
				report_error($sformatf("drive_three %0d exp %0d", got.drive_three,
					e.drive_three));
			if (got.drive_four !== e.drive_four)
				report_error($sformatf("drive_four %0d exp %0d", got.drive_four, e.drive_four));
		endfunction

		function void report_error(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	drive_scoreboard sb;
	int idle_cycles;
	bit stall_busy;

	omni_wheel_speed_mixer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// accepted words go to the scoreboard; watchdog on accept activity
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_input(in_data);
			if (out_valid && !out_stall) sb.check_output(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && idle_cycles >= IdleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// output stall pattern, with quiet stretches where it never stalls
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_busy || $urandom_range(0, 9) < 3) begin
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else begin
				n = gap_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
				@(posedge clk);
			end
		end
	end

	task automatic send_word(in_word_t w);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (Latency + 5) @(posedge clk);
	endtask

	// one write, then cfg_we goes low before returning, so back to back calls never collide
	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	function automatic in_word_t make_word(logic signed [15:0] sa, logic signed [15:0] ha,
		logic signed [15:0] sb_, logic signed [15:0] hb, logic signed [15:0] tr);
		in_word_t w;
		w.speed_a = sa;
		w.heading_a = ha;
		w.speed_b = sb_;
		w.heading_b = hb;
		w.turn_rate = tr;
		return w;
	endfunction

	// headings mostly in range, sometimes any 16-bit value
	function automatic logic [15:0] rand_heading();
		if ($urandom_range(0, 9) == 0) return 16'($urandom());
		return 16'($urandom_range(0, 46080) - 23040);
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		w = '0;
		w.speed_a = 16'($urandom());
		w.heading_a = rand_heading();
		w.speed_b = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom());
		w.heading_b = rand_heading();
		w.turn_rate = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 400) - 200)
			: 16'($urandom());
		return w;
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) send_word(rand_word());
	endtask

	initial begin
		in_word_t w;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_cycles = 0;
		stall_busy = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under reset defaults
		send_word(make_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
		send_word(make_word(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
		send_word(make_word(-16'sd32768, 16'sd23040, 16'sd0, 16'sd0, 16'sd0));
		send_word(make_word(16'sd32767, -16'sd23040, 16'sd32767, 16'sd23040, 16'sd32767));
		send_word(make_word(16'sd1000, 16'sd5760, 16'sd0, -16'sd5760, -16'sd32768));
		// cancelling vectors give no speed term
		send_word(make_word(16'sd20000, 16'sd2880, 16'sd20000, 16'sd14400, 16'sd0));
		send_word(make_word(16'sd20000, 16'sd2880, -16'sd20000, 16'sd2880, 16'sd5));
		// headings out of range and at wrap edges
		send_word(make_word(16'sd12345, 16'sh7fff, 16'sd3000, 16'sh8000, 16'sd100));
		send_word(make_word(-16'sd1, 16'shffff, 16'sd1, 16'sd11520, -16'sd1));
		send_word(make_word(16'sd500, 16'sd11519, 16'sd500, -16'sd11520, 16'sd32767));
		drain();

		// extreme registers, angles above 359, bad index
		write_reg(REG_ANGLE_ONE, 16'd0);
		write_reg(REG_ANGLE_TWO, 16'd359);
		write_reg(REG_ANGLE_THREE, 16'd511);
		write_reg(REG_ANGLE_FOUR, 16'hffff);
		write_reg(REG_DRIVE_GAIN, 16'h8000);
		write_reg(REG_TURN_ARM, 16'hffff);
		cfg_we <= 1'b1;
		cfg_index <= 3'd6;
		cfg_wdata <= 16'h1234;
		@(posedge clk);
		cfg_index <= 3'd7;
		@(posedge clk);
		cfg_we <= 1'b0;
		send_word(make_word(16'sd32767, 16'sd0, 16'sd32767, 16'sd0, 16'sd32767));
		send_word(make_word(-16'sd32768, 16'sd11520, 16'sd0, 16'sd0, -16'sd32768));
		send_word(make_word(16'sd100, 16'sd64, 16'sd0, 16'sd0, 16'sd0));
		random_phase(250);
		drain();

		write_reg(REG_DRIVE_GAIN, 16'h7fff);
		write_reg(REG_TURN_ARM, 16'd0);
		random_phase(250);
		drain();

		// several random settings, one quiet run with no output stall
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_ANGLE_ONE, 16'($urandom_range(0, 511)));
			write_reg(REG_ANGLE_TWO, 16'($urandom_range(0, 359)));
			write_reg(REG_ANGLE_THREE, 16'($urandom_range(0, 359)));
			write_reg(REG_ANGLE_FOUR, 16'($urandom_range(0, 511)));
			write_reg(REG_DRIVE_GAIN, (p == 0) ? 16'd1 : 16'($urandom()));
			write_reg(REG_TURN_ARM, 16'($urandom()));
			stall_busy = (p == 2);
			random_phase(240);
			drain();
		end
		stall_busy = 1'b0;

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
